// File: design/dpb_pkg.sv
// shared types and constants for the depth pixel back-projection block
// no dependencies
package dpb_pkg;

  localparam int CX_W    = 13;
  localparam int INV_W   = 19;
  localparam int FW_W    = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int FRAC_SHIFT = 21;
  localparam int OUT_W   = 32;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_INV_FX   = 3'd2;
  localparam logic [2:0] REG_INV_FY   = 3'd3;
  localparam logic [2:0] REG_FRAME_W  = 3'd4;

  localparam logic [CX_W-1:0]  CENTER_X_RST = 13'd649;
  localparam logic [CX_W-1:0]  CENTER_Y_RST = 13'd507;
  localparam logic [INV_W-1:0] INV_FX_RST   = 19'd32388;
  localparam logic [INV_W-1:0] INV_FY_RST   = 19'd32326;
  localparam logic [FW_W-1:0]  FRAME_W_RST  = 12'd640;

  typedef struct packed {
    logic [CX_W-1:0]  center_x_half;
    logic [CX_W-1:0]  center_y_half;
    logic [INV_W-1:0] inv_focal_x;
    logic [INV_W-1:0] inv_focal_y;
    logic [FW_W-1:0]  frame_width;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: design/dpb_fifo.sv
// short register queue between the front and the back part
// depends on dpb_pkg for the status struct
module dpb_fifo import dpb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output q_status_t        status_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic full, empty, do_push, do_pop;

  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign full    = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;
  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;

  assign rdata_o  = mem_q[rd_ptr_q[AW-1:0]];
  assign status_o = '{full: full, empty: empty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

// File: design/dpb_front.sv
// front part: pixel counters, offset from the principal point, zero-depth filter
// depends on dpb_pkg
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAG_W = 15,
  parameter int PW = 72
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic [COLOR_W-1:0] blue_i,
  input  logic [COLOR_W-1:0] green_i,
  input  logic [COLOR_W-1:0] red_i,
  input  logic               frame_start_i,
  input  q_status_t          q_status_i,
  output logic               push_o,
  output logic [PW-1:0]      item_o
);

  localparam int CW = (COORD_BITS + 1 > FW_W) ? COORD_BITS + 1 : FW_W;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d, col, row;
  logic [COORD_BITS:0]   next_col;
  logic [FW_W-1:0]       width;
  logic                  wrap, accept;
  logic                  neg_x, neg_y;
  logic [MAG_W-1:0]      mag_x, mag_y;
  logic [MAG_W:0]        tx, ty, cxe, cye, dx, dy;

  assign accept     = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;

  assign col = frame_start_i ? '0 : col_q;
  assign row = frame_start_i ? '0 : row_q;

  // signed half-pixel offset split into sign and magnitude
  assign tx  = (MAG_W+1)'({col, 1'b0});
  assign ty  = (MAG_W+1)'({row, 1'b0});
  assign cxe = (MAG_W+1)'(cfg_i.center_x_half);
  assign cye = (MAG_W+1)'(cfg_i.center_y_half);
  assign dx  = tx - cxe;
  assign dy  = ty - cye;
  assign neg_x = dx[MAG_W];
  assign neg_y = dy[MAG_W];
  assign mag_x = neg_x ? MAG_W'(cxe - tx) : dx[MAG_W-1:0];
  assign mag_y = neg_y ? MAG_W'(cye - ty) : dy[MAG_W-1:0];

  // column wrap at frame width, zero width acts as one
  assign width    = (cfg_i.frame_width == '0) ? FW_W'(1) : cfg_i.frame_width;
  assign next_col = (COORD_BITS+1)'(col) + 1'b1;
  assign wrap     = (CW'(next_col) >= CW'(width)) || next_col[COORD_BITS];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (wrap) begin
        col_d = '0;
        row_d = row + 1'b1;
      end else begin
        col_d = next_col[COORD_BITS-1:0];
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o = accept && (depth_mm_i != '0);
  assign item_o = {neg_x, mag_x, neg_y, mag_y, depth_mm_i, blue_i, green_i, red_i};

endmodule

// File: design/dpb_back.sv
// back part: two multiply stages, rounding and saturation into the output register
// depends on dpb_pkg
module dpb_back import dpb_pkg::*; #(
  parameter int MAG_W = 15,
  parameter int PW = 72
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_status_t          q_status_i,
  input  logic [PW-1:0]      item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OUT_W-1:0]   point_x_o,
  output logic [OUT_W-1:0]   point_y_o,
  output logic [DEPTH_W-1:0] point_z_o,
  output logic [COLOR_W-1:0] out_blue_o,
  output logic [COLOR_W-1:0] out_green_o,
  output logic [COLOR_W-1:0] out_red_o
);

  localparam int P1_W = MAG_W + DEPTH_W;
  localparam int P2_W = P1_W + INV_W;
  localparam int QW   = P2_W + 1 - FRAC_SHIFT;
  localparam int QX   = (QW > OUT_W + 1) ? QW : OUT_W + 1;
  localparam int RGB_W = 3 * COLOR_W;

  logic                  neg_x, neg_y;
  logic [MAG_W-1:0]      mag_x, mag_y;
  logic [DEPTH_W-1:0]    z;
  logic [RGB_W-1:0]      rgb;
  logic                  adv;

  logic                  s1_valid_q, s2_valid_q;
  logic                  s1_negx_q, s1_negy_q, s2_negx_q, s2_negy_q;
  logic [P1_W-1:0]       s1_px_q, s1_py_q;
  logic [P2_W-1:0]       s2_px_q, s2_py_q;
  logic [DEPTH_W-1:0]    s1_z_q, s2_z_q;
  logic [RGB_W-1:0]      s1_rgb_q, s2_rgb_q;
  logic [OUT_W-1:0]      x_d, y_d;

  assign {neg_x, mag_x, neg_y, mag_y, z, rgb} = item_i;

  // the whole pipe moves unless the output register is held
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !q_status_i.empty;

  function automatic logic [OUT_W-1:0] round_sat(input logic [P2_W-1:0] p, input logic neg);
    logic [P2_W:0]      sum;
    logic [QX-1:0]      q;
    logic [OUT_W-1:0]   r;
    sum = (P2_W+1)'(p) + (P2_W+1)'(1 << (FRAC_SHIFT - 1));
    q   = QX'(sum >> FRAC_SHIFT);
    if (neg) begin
      if (q > QX'(64'h8000_0000)) r = 32'h8000_0000;
      else r = q[OUT_W-1:0];
      r = 32'd0 - r;
    end else begin
      if (q > QX'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = q[OUT_W-1:0];
    end
    return r;
  endfunction

  assign x_d = round_sat(s2_px_q, s2_negx_q);
  assign y_d = round_sat(s2_py_q, s2_negy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_status_i.empty;
      s2_valid_q  <= s1_valid_q;
      out_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_negx_q <= neg_x;
      s1_negy_q <= neg_y;
      s1_px_q   <= P1_W'(mag_x) * P1_W'(z);
      s1_py_q   <= P1_W'(mag_y) * P1_W'(z);
      s1_z_q    <= z;
      s1_rgb_q  <= rgb;

      s2_negx_q <= s1_negx_q;
      s2_negy_q <= s1_negy_q;
      s2_px_q   <= P2_W'(s1_px_q) * P2_W'(cfg_i.inv_focal_x);
      s2_py_q   <= P2_W'(s1_py_q) * P2_W'(cfg_i.inv_focal_y);
      s2_z_q    <= s1_z_q;
      s2_rgb_q  <= s1_rgb_q;

      point_x_o <= x_d;
      point_y_o <= y_d;
      point_z_o <= s2_z_q;
      {out_blue_o, out_green_o, out_red_o} <= s2_rgb_q;
    end
  end

endmodule

// File: design/depth_pixel_backprojection.sv
// top level of the depth pixel back-projection block: register file and wiring
// depends on dpb_pkg, dpb_front, dpb_fifo, dpb_back
//
// usage
//   pixels enter in raster order on the input channel (in_valid_i / in_stall_o),
//   each with a 16-bit depth in mm, blue, green, red and a frame start flag
//   a pixel with nonzero depth yields one point transaction on the output channel
//   (out_valid_o / out_stall_i): x and y in 1/16 mm, signed and saturated, z in mm
//   and the colour passed through; a zero-depth pixel yields nothing but still
//   advances the column and row counters
//   throughput is one pixel per cycle; the front part takes a pixel whenever the
//   four-entry queue has room, and the back part runs a three-stage pipe
//   (depth multiply, reciprocal focal multiply, rounding and clamp into the output
//   register), which each point passes through after it leaves the queue
//   when the receiver stalls, the back pipe holds, the queue fills, and in_stall_o
//   rises once the queue is full; nothing is dropped; reset clears the counters,
//   the queue and the pipe and loads the register defaults; the user must write
//   registers over the apb port only while the block is idle; nothing enforces it
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // pixel input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic [COLOR_W-1:0] blue_i,
  input  logic [COLOR_W-1:0] green_i,
  input  logic [COLOR_W-1:0] red_i,
  input  logic               frame_start_i,
  // point output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OUT_W-1:0]   point_x_o,
  output logic [OUT_W-1:0]   point_y_o,
  output logic [DEPTH_W-1:0] point_z_o,
  output logic [COLOR_W-1:0] out_blue_o,
  output logic [COLOR_W-1:0] out_green_o,
  output logic [COLOR_W-1:0] out_red_o
);

  // magnitude of the half-pixel offset covers twice the largest coordinate
  localparam int MAG_W   = (COORD_BITS + 1 > CX_W) ? COORD_BITS + 1 : CX_W;
  localparam int ITEM_W  = 2 * (MAG_W + 1) + DEPTH_W + 3 * COLOR_W;
  localparam int Q_DEPTH = 4;

  cfg_t        cfg_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  q_status_t   q_status;
  logic        push, pop;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  // ---------------------------------------------------------------------------
  // register file, one 32-bit word per register, low address bits ignored
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x_half <= CENTER_X_RST;
      cfg_q.center_y_half <= CENTER_Y_RST;
      cfg_q.inv_focal_x   <= INV_FX_RST;
      cfg_q.inv_focal_y   <= INV_FY_RST;
      cfg_q.frame_width   <= FRAME_W_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CENTER_X: cfg_q.center_x_half <= pwdata[CX_W-1:0];
        REG_CENTER_Y: cfg_q.center_y_half <= pwdata[CX_W-1:0];
        REG_INV_FX:   cfg_q.inv_focal_x   <= pwdata[INV_W-1:0];
        REG_INV_FY:   cfg_q.inv_focal_y   <= pwdata[INV_W-1:0];
        REG_FRAME_W:  cfg_q.frame_width   <= pwdata[FW_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = 32'(cfg_q.center_x_half);
      REG_CENTER_Y: prdata = 32'(cfg_q.center_y_half);
      REG_INV_FX:   prdata = 32'(cfg_q.inv_focal_x);
      REG_INV_FY:   prdata = 32'(cfg_q.inv_focal_y);
      REG_FRAME_W:  prdata = 32'(cfg_q.frame_width);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: counters and offsets, drops zero-depth pixels
  // ---------------------------------------------------------------------------
  dpb_front #(
    .COORD_BITS(COORD_BITS),
    .MAG_W     (MAG_W),
    .PW        (ITEM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .depth_mm_i   (depth_mm_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .frame_start_i(frame_start_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (q_wdata)
  );

  // queue decouples pixel intake from the multiply pipe
  dpb_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .status_o(q_status)
  );

  // ---------------------------------------------------------------------------
  // back: projection pipe and output register
  // ---------------------------------------------------------------------------
  dpb_back #(
    .MAG_W(MAG_W),
    .PW   (ITEM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .item_i     (q_rdata),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o),
    .point_z_o  (point_z_o),
    .out_blue_o (out_blue_o),
    .out_green_o(out_green_o),
    .out_red_o  (out_red_o)
  );

endmodule
